### design/dlestx_pkg.sv
`timescale 1ns / 1ps

package dlestx_pkg;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned ADDR_W  = 6;
  localparam int unsigned DEPTH   = 64;

  typedef logic [7:0] byte_t;

  localparam byte_t START_FIRST_RST  = 8'h10;
  localparam byte_t START_SECOND_RST = 8'h02;
  localparam byte_t END_FIRST_RST    = 8'h10;
  localparam byte_t END_SECOND_RST   = 8'h03;

  typedef enum logic [1:0] {
    STAT_BYTE    = 2'd0,
    STAT_SUM     = 2'd1,
    STAT_OVERLAP = 2'd2,
    STAT_LONG    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_START_FIRST  = 2'd0,
    REG_START_SECOND = 2'd1,
    REG_END_FIRST    = 2'd2,
    REG_END_SECOND   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SHOW
  } ctrl_state_e;

  typedef struct packed {
    byte_t start_first;
    byte_t start_second;
    byte_t end_first;
    byte_t end_second;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic rd_issue;
    logic load_byte;
    logic out_pop;
  } dp_cmd_t;

  typedef struct packed {
    logic end_ok;
    logic out_valid;
    logic rd_last;
  } dp_stat_t;

endpackage

### design/dlestx_ctrl.sv
`timescale 1ns / 1ps

module dlestx_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_stall_i,
  input  dlestx_pkg::dp_stat_t stat_i,
  output logic                in_stall_o,
  output dlestx_pkg::dp_cmd_t  cmd_o
);
  import dlestx_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    out_free      = !stat_i.out_valid || !out_stall_i;
    cmd_o         = '0;
    cmd_o.out_pop = stat_i.out_valid && !out_stall_i;
    in_stall_o    = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = !out_free;
        cmd_o.take = in_valid_i && out_free;
        if (cmd_o.take && stat_i.end_ok) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_SHOW;
      end
      S_SHOW: begin
        if (out_free) begin
          cmd_o.load_byte = 1'b1;
          state_d         = stat_i.rd_last ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### design/dlestx_dp.sv
`timescale 1ns / 1ps

module dlestx_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dlestx_pkg::cfg_t     cfg_i,
  input  dlestx_pkg::byte_t    rx_byte_i,
  input  dlestx_pkg::dp_cmd_t  cmd_i,
  output dlestx_pkg::dp_stat_t stat_o,
  output logic                 out_valid_o,
  output dlestx_pkg::byte_t    packet_byte_o,
  output logic                 last_o,
  output logic [1:0]           status_o,
  output logic [6:0]           packet_length_o
);
  import dlestx_pkg::*;

  // framing state
  logic              in_packet_q;
  byte_t             prev_q;
  logic              prev_valid_q;
  byte_t             prev2_q;
  logic [CNT_W-1:0]  count_q;
  byte_t             sum0_q, sum1_q;
  byte_t             head0_q, head1_q;

  // packet store and drain
  byte_t             mem [DEPTH];
  byte_t             rd_data_q;
  logic [ADDR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0]  pkt_len_q;

  // result register
  logic              out_valid_q;
  byte_t             out_byte_q;
  logic              out_last_q;
  status_e           out_status_q;
  logic [CNT_W-1:0]  out_len_q;

  logic hunt_start, start_pair, overlap, too_long, store, end_pair, sum_ok;
  logic begin_pkt, err_load;
  status_e          err_status;
  logic [CNT_W-1:0] err_len;
  byte_t            drain_byte;

  always_comb begin
    start_pair = (prev_q == cfg_i.start_first) && (rx_byte_i == cfg_i.start_second);
    hunt_start = !in_packet_q && prev_valid_q && start_pair;
    overlap    = in_packet_q && start_pair;
    too_long   = in_packet_q && !start_pair && (count_q >= CNT_W'(MAX_LEN));
    store      = in_packet_q && !start_pair && !too_long;
    end_pair   = (prev_q == cfg_i.end_first) && (rx_byte_i == cfg_i.end_second);
    sum_ok     = (prev2_q == sum1_q);
    begin_pkt  = hunt_start || overlap;

    err_load   = cmd_i.take && (overlap || too_long || (store && end_pair && !sum_ok));
    err_status = STAT_SUM;
    err_len    = count_q + CNT_W'(1);
    if (overlap) begin
      err_status = STAT_OVERLAP;
      err_len    = count_q - CNT_W'(1);
    end else if (too_long) begin
      err_status = STAT_LONG;
      err_len    = count_q;
    end

    if (rd_ptr_q == ADDR_W'(0)) begin
      drain_byte = head0_q;
    end else if (rd_ptr_q == ADDR_W'(1)) begin
      drain_byte = head1_q;
    end else begin
      drain_byte = rd_data_q;
    end

    stat_o.end_ok    = store && end_pair && sum_ok;
    stat_o.out_valid = out_valid_q;
    stat_o.rd_last   = ({1'b0, rd_ptr_q} == (pkt_len_q - CNT_W'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q  <= 1'b0;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      count_q      <= '0;
      sum0_q       <= '0;
      sum1_q       <= '0;
      rd_ptr_q     <= '0;
      pkt_len_q    <= '0;
    end else begin
      if (cmd_i.take) begin
        prev_q       <= rx_byte_i;
        prev_valid_q <= 1'b1;
        if (begin_pkt) begin
          in_packet_q <= 1'b1;
          count_q     <= CNT_W'(2);
          sum0_q      <= prev_q;
          sum1_q      <= '0;
        end else if (too_long) begin
          in_packet_q <= 1'b0;
          count_q     <= '0;
        end else if (store) begin
          sum0_q <= sum0_q + prev_q;
          sum1_q <= sum0_q;
          if (end_pair) begin
            in_packet_q  <= 1'b0;
            count_q      <= '0;
            prev_valid_q <= 1'b0;
            pkt_len_q    <= count_q + CNT_W'(1);
            rd_ptr_q     <= '0;
          end else begin
            count_q <= count_q + CNT_W'(1);
          end
        end
      end
      if (cmd_i.load_byte) begin
        rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
      end
    end
  end

  // start pair and byte before last stored byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && begin_pkt) begin
      head0_q <= prev_q;
      head1_q <= rx_byte_i;
      prev2_q <= prev_q;
    end else if (cmd_i.take && store) begin
      prev2_q <= prev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && store) begin
      mem[count_q[ADDR_W-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (err_load || cmd_i.load_byte) begin
      out_valid_q <= 1'b1;
    end else if (cmd_i.out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (err_load) begin
      out_byte_q   <= '0;
      out_last_q   <= 1'b1;
      out_status_q <= err_status;
      out_len_q    <= err_len;
    end else if (cmd_i.load_byte) begin
      out_byte_q   <= drain_byte;
      out_last_q   <= stat_o.rd_last;
      out_status_q <= STAT_BYTE;
      out_len_q    <= pkt_len_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign packet_byte_o   = out_byte_q;
  assign last_o          = out_last_q;
  assign status_o        = out_status_q;
  assign packet_length_o = out_len_q;

endmodule

### design/dle_stx_packet_deframer_sum_check.sv
`timescale 1ns / 1ps
// channel   valid        stall        payload
// in        in_valid_i   in_stall_o   rx_byte_i
// out       out_valid_o  out_stall_i  packet_byte_o, last_o, status_o, packet_length_o
// cfg       psel/penable/pwrite, pready always high, paddr[3:2] selects register
//
// one cycle per received byte unless a drain runs or a result waits under out_stall_i
// a good packet drains byte by byte: a packet store read, then an output load
// error results load the output register in the cycle their byte is taken
// reset: start pair 0x10 0x02, end pair 0x10 0x03, hunting for a start pair
// in_stall_o is high while a result waits under out_stall_i and during a drain

module dle_stx_packet_deframer_sum_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  packet_byte_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  output logic [6:0]  packet_length_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dlestx_pkg::*;

  cfg_t     cfg_q;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  cfg_reg_e reg_sel;

  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_first  <= START_FIRST_RST;
      cfg_q.start_second <= START_SECOND_RST;
      cfg_q.end_first    <= END_FIRST_RST;
      cfg_q.end_second   <= END_SECOND_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_START_FIRST:  cfg_q.start_first  <= pwdata[7:0];
        REG_START_SECOND: cfg_q.start_second <= pwdata[7:0];
        REG_END_FIRST:    cfg_q.end_first    <= pwdata[7:0];
        REG_END_SECOND:   cfg_q.end_second   <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_START_FIRST:  prdata = {24'd0, cfg_q.start_first};
      REG_START_SECOND: prdata = {24'd0, cfg_q.start_second};
      REG_END_FIRST:    prdata = {24'd0, cfg_q.end_first};
      REG_END_SECOND:   prdata = {24'd0, cfg_q.end_second};
      default:          prdata = '0;
    endcase
  end

  dlestx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  dlestx_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .rx_byte_i       (rx_byte_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .packet_byte_o   (packet_byte_o),
    .last_o          (last_o),
    .status_o        (status_o),
    .packet_length_o (packet_length_o)
  );

endmodule

### design/dlestx_chk.sv
`timescale 1ns / 1ps

module dlestx_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] packet_byte_o,
  input logic       last_o,
  input logic [1:0] status_o,
  input logic [6:0] packet_length_o
);
  import dlestx_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(packet_byte_o) &&
      $stable(last_o) && $stable(status_o) && $stable(packet_length_o))
    else $error("stalled result changed");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_BYTE) |-> last_o && (packet_byte_o == 8'd0))
    else $error("error result not a single zero last result");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> packet_length_o <= 7'(MAX_LEN))
    else $error("packet length beyond limit");

  a_good_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_BYTE) |-> packet_length_o >= 7'd3)
    else $error("good packet shorter than three bytes");

  a_back_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request taken while result is stalled");

endmodule

bind dle_stx_packet_deframer_sum_check dlestx_chk u_dlestx_chk (.*);
